FILE: src/annexb_to_length_prefixed_nal_assert.svh
// Assertion macros used by the anl_back module of the annexb_to_length_prefixed_nal RTL.
`ifndef ANNEXB_TO_LENGTH_PREFIXED_NAL_ASSERT_SVH
`define ANNEXB_TO_LENGTH_PREFIXED_NAL_ASSERT_SVH

// Condition holds at every edge out of reset (module has clk and arst_n).
`define ANL_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ANL_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ANL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/anl_pkg.sv
// Shared types and constants of the Annex B to length-prefixed NAL converter.
package anl_pkg;

	localparam logic [7:0] BYTE_ZERO      = 8'h00;
	localparam logic [7:0] BYTE_START_END = 8'h01;
	localparam logic [1:0] HELD_MAX       = 2'd3;

	localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
	localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
	localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

	localparam logic KIND_PAYLOAD    = 1'b0;
	localparam logic KIND_DESCRIPTOR = 1'b1;

	localparam int CMDQ_DEPTH    = 4;
	localparam int CMDQ_PTR_BITS = 2;
	localparam int CMDQ_CNT_BITS = 3;

	// Work for the back end caused by one input byte:
	// zeros payload zero bytes, then an optional data byte, then an optional descriptor.
	typedef struct packed {
		logic [1:0] zeros;
		logic       has_byte;
		logic [7:0] data;
		logic       desc;
	} anl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} anl_q_status_t;

endpackage

FILE: src/anl_front.sv
// Front end: start code detection and classification of each input byte.
module anl_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_buffer,
	input  anl_pkg::anl_q_status_t q_status,
	output logic                   push,
	output anl_pkg::anl_cmd_t      push_cmd
);

	logic [1:0] held_q;
	logic       nonempty_q;
	logic [1:0] held_nx;
	logic       nonempty_nx;
	logic       fin;
	logic       payload;
	logic       accept;
	anl_pkg::anl_cmd_t cmd;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd         = '0;
		held_nx     = held_q;
		fin         = 1'b0;
		if (data_byte == anl_pkg::BYTE_ZERO) begin
			if (held_q != anl_pkg::HELD_MAX) begin
				held_nx = held_q + 2'd1;
			end else begin
				cmd.has_byte = 1'b1;
				cmd.data     = anl_pkg::BYTE_ZERO;
			end
		end else if (data_byte == anl_pkg::BYTE_START_END && held_q == anl_pkg::HELD_MAX) begin
			held_nx = 2'd0;
			fin     = 1'b1;
		end else begin
			cmd.zeros    = held_q;
			cmd.has_byte = 1'b1;
			cmd.data     = data_byte;
			held_nx      = 2'd0;
		end
		// flush the held zeros at end of buffer; they are all zeros, so order is free
		if (end_of_buffer) begin
			cmd.zeros = cmd.zeros + held_nx;
			held_nx   = 2'd0;
			fin       = 1'b1;
		end
		payload     = (cmd.zeros != 2'd0) || cmd.has_byte;
		cmd.desc    = fin && (nonempty_q || payload);
		nonempty_nx = !fin && (nonempty_q || payload);
	end

	assign push     = accept && (payload || cmd.desc);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 2'd0;
			nonempty_q <= 1'b0;
		end else if (accept) begin
			held_q     <= held_nx;
			nonempty_q <= nonempty_nx;
		end
	end

endmodule

FILE: src/anl_cmdq.sv
// Short command queue between the front end and the back end.
module anl_cmdq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  anl_pkg::anl_cmd_t      push_cmd,
	input  logic                   pop,
	output anl_pkg::anl_cmd_t      head_cmd,
	output anl_pkg::anl_q_status_t status
);

	anl_pkg::anl_cmd_t slots_q [anl_pkg::CMDQ_DEPTH];
	logic [anl_pkg::CMDQ_PTR_BITS-1:0] wr_ptr_q;
	logic [anl_pkg::CMDQ_PTR_BITS-1:0] rd_ptr_q;
	logic [anl_pkg::CMDQ_CNT_BITS-1:0] count_q;

	assign status.full  = (count_q == anl_pkg::CMDQ_CNT_BITS'(anl_pkg::CMDQ_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/anl_back.sv
// Back end: unit length and type tracking, sticky flags, result sequencing.
`include "annexb_to_length_prefixed_nal_assert.svh"

module anl_back #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  anl_pkg::anl_cmd_t      head_cmd,
	input  anl_pkg::anl_q_status_t q_status,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   kind,
	output logic [7:0]             out_byte,
	output logic [31:0]            unit_length,
	output logic [4:0]             unit_type,
	output logic                   sps_seen,
	output logic                   pps_seen,
	output logic                   idr_seen,
	output logic                   last_of_run
);

	// work left for the command in progress
	logic [1:0]             zeros_left_q;
	logic                   byte_left_q;
	logic                   desc_left_q;
	logic [7:0]             data_q;

	logic [LENGTH_BITS-1:0] bytes_q;
	logic [4:0]             type_q;
	logic                   sps_q, pps_q, idr_q;

	logic                   out_valid_q;
	logic                   kind_q;
	logic [7:0]             out_byte_q;
	logic [31:0]            length_q;
	logic [4:0]             type_out_q;
	logic                   sps_out_q, pps_out_q, idr_out_q;
	logic                   last_q;

	logic       busy, out_free, advance, load;
	logic       emit_zero, emit_byte, emit_desc;
	logic [1:0] zeros_nx;
	logic       byte_nx, desc_nx, is_last;
	logic [7:0] pay_byte;
	logic       sps_nx, pps_nx, idr_nx;

	always_comb begin
		busy      = (zeros_left_q != 2'd0) || byte_left_q || desc_left_q;
		out_free  = !out_valid_q || !out_stall;
		advance   = busy && out_free;
		emit_zero = (zeros_left_q != 2'd0);
		emit_byte = !emit_zero && byte_left_q;
		emit_desc = !emit_zero && !byte_left_q;
		pay_byte  = emit_zero ? anl_pkg::BYTE_ZERO : data_q;
		zeros_nx  = emit_zero ? zeros_left_q - 2'd1 : zeros_left_q;
		byte_nx   = byte_left_q && !emit_byte;
		desc_nx   = desc_left_q && !emit_desc;
		is_last   = (zeros_nx == 2'd0) && !byte_nx && !desc_nx;
		load      = !q_status.empty && (!busy || (advance && is_last));
		sps_nx    = sps_q || (type_q == anl_pkg::NAL_TYPE_SPS);
		pps_nx    = pps_q || (type_q == anl_pkg::NAL_TYPE_PPS);
		idr_nx    = idr_q || (type_q == anl_pkg::NAL_TYPE_IDR);
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zeros_left_q <= 2'd0;
			byte_left_q  <= 1'b0;
			desc_left_q  <= 1'b0;
			bytes_q      <= '0;
			type_q       <= 5'd0;
			sps_q        <= 1'b0;
			pps_q        <= 1'b0;
			idr_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				zeros_left_q <= head_cmd.zeros;
				byte_left_q  <= head_cmd.has_byte;
				desc_left_q  <= head_cmd.desc;
			end else if (advance) begin
				zeros_left_q <= zeros_nx;
				byte_left_q  <= byte_nx;
				desc_left_q  <= desc_nx;
			end
			if (out_free) begin
				out_valid_q <= advance;
			end
			if (advance) begin
				if (emit_desc) begin
					sps_q   <= sps_nx;
					pps_q   <= pps_nx;
					idr_q   <= idr_nx;
					bytes_q <= '0;
					type_q  <= 5'd0;
				end else begin
					if (bytes_q == '0) begin
						type_q <= pay_byte[4:0];
					end
					// saturate at all ones
					if (bytes_q != '1) begin
						bytes_q <= bytes_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= head_cmd.data;
		end
		if (advance) begin
			last_q <= is_last;
			if (emit_desc) begin
				kind_q     <= anl_pkg::KIND_DESCRIPTOR;
				out_byte_q <= 8'd0;
				length_q   <= 32'(bytes_q);
				type_out_q <= type_q;
				sps_out_q  <= sps_nx;
				pps_out_q  <= pps_nx;
				idr_out_q  <= idr_nx;
			end else begin
				kind_q     <= anl_pkg::KIND_PAYLOAD;
				out_byte_q <= pay_byte;
				length_q   <= 32'd0;
				type_out_q <= 5'd0;
				sps_out_q  <= sps_q;
				pps_out_q  <= pps_q;
				idr_out_q  <= idr_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_byte    = out_byte_q;
	assign unit_length = length_q;
	assign unit_type   = type_out_q;
	assign sps_seen    = sps_out_q;
	assign pps_seen    = pps_out_q;
	assign idr_seen    = idr_out_q;
	assign last_of_run = last_q;

	`ANL_ASSERT_IMPLY(a_desc_nonempty, out_valid_q && kind_q == anl_pkg::KIND_DESCRIPTOR, length_q != 32'd0, "descriptor for an empty unit")
	`ANL_ASSERT_IMPLY(a_desc_sps_flag, out_valid_q && kind_q == anl_pkg::KIND_DESCRIPTOR && type_out_q == anl_pkg::NAL_TYPE_SPS, sps_out_q, "SPS descriptor without sps flag")
	`ANL_ASSERT_IMPLY(a_pop_only_when_free, pop, !busy || (advance && is_last), "command loaded over unfinished work")
	`ANL_ASSERT_NEXT(a_sticky_sps, sps_q, sps_q, "sps flag cleared")

endmodule

FILE: src/annexb_to_length_prefixed_nal.sv
// Top level of the Annex B start code to length-prefixed NAL converter.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall    | data_byte, end_of_buffer
//  out     | source    | out_valid / out_stall  | kind, out_byte, unit_length, unit_type,
//          |           |                        | sps_seen, pps_seen, idr_seen, last_of_run
//
// One byte is accepted per cycle while the four-entry command queue has room.
// Results leave at one per cycle from the output register while out_stall is low;
// a byte causes zero to five results, and the queue absorbs the extra results of
// a byte that releases held zeros or closes a unit.
// An accepted byte goes through the queue, the work registers and the output register.
// Reset (arst_n low) clears held zeros, unit length and type, sticky flags and the queue.
// out_stall holds the output register; in_stall rises only when the queue is full.
module annexb_to_length_prefixed_nal #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  out_byte,
	output logic [31:0] unit_length,
	output logic [4:0]  unit_type,
	output logic        sps_seen,
	output logic        pps_seen,
	output logic        idr_seen,
	output logic        last_of_run
);

	// front -> queue -> back
	logic                   push;
	logic                   pop;
	anl_pkg::anl_cmd_t      push_cmd;
	anl_pkg::anl_cmd_t      head_cmd;
	anl_pkg::anl_q_status_t q_status;

	// classify each byte: hold zeros, drop start codes, decide the work to do
	anl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.q_status      (q_status),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// decouple byte intake from result delivery
	anl_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_status)
	);

	// count unit bytes, track type and flags, emit one result per transaction
	anl_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_cmd    (head_cmd),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_byte    (out_byte),
		.unit_length (unit_length),
		.unit_type   (unit_type),
		.sps_seen    (sps_seen),
		.pps_seen    (pps_seen),
		.idr_seen    (idr_seen),
		.last_of_run (last_of_run)
	);

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the Annex B start code to length-prefixed NAL converter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 11;
	localparam int LENGTH_BITS     = 32;
	localparam int RANDOM_ITEMS    = 335;
	localparam int MAX_GAP         = 10;
	localparam int PRESSURE_AFTER  = 150;   // results taken before the long hold-off
	localparam int PRESSURE_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 16;    // quiet time after the last owed result, to catch strays
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int REPORT_LIMIT    = 10;
	localparam int BURST_SPAN      = 32;    // random items between idle-mode changes

	localparam logic [32:0] UNIT_LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

	// One result transaction of the output channel.
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [31:0] length;
		logic [4:0]  nal_type;
		logic        sps;
		logic        pps;
		logic        idr;
		logic        last;
	} nal_result_t;

	// One input transaction.
	typedef struct packed {
		logic [7:0] data;
		logic       eob;
	} stream_item_t;

	// Directed row: either typed (zero or one result spelled out) or predicted.
	typedef struct packed {
		logic [7:0]  data;
		logic        eob;
		logic        typed;
		logic        has_result;
		nal_result_t result;
	} stim_row_t;

	localparam nal_result_t NO_RESULT = '0;
	localparam int DIRECTED_ROWS = 27;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// leading zeros and a start code that closes an empty unit: silent
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, 1'b1, 1'b0, NO_RESULT},
		// SPS header byte passes straight through, flags still clear
		'{8'h67, 1'b0, 1'b1, 1'b1,
			'{anl_pkg::KIND_PAYLOAD, 8'h67, 32'd0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{8'h42, 1'b0, 1'b0, 1'b0, NO_RESULT},
		// four zeros: the oldest held zero leaks out as payload
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		// start code closes the three-byte SPS unit, flag already set
		'{8'h01, 1'b0, 1'b1, 1'b1,
			'{anl_pkg::KIND_DESCRIPTOR, 8'h00, 32'd3, anl_pkg::NAL_TYPE_SPS,
				1'b1, 1'b0, 1'b0, 1'b1}},
		// PPS unit with an emulation prevention pattern and a three-byte start code
		'{8'h68, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h03, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
		// end of buffer flushes the PPS unit
		'{8'hFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
		// one-byte IDR unit inside a single-byte buffer
		'{8'h65, 1'b1, 1'b0, 1'b0, NO_RESULT},
		// a lone held zero flushed by end of buffer
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
		// three held zeros, then a zero with end of buffer: five results
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
		// all-ones header (type 31), then a 01 byte that is no start code
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b1, 1'b0, 1'b0, NO_RESULT}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte     = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic        kind;
	logic [7:0]  out_byte;
	logic [31:0] unit_length;
	logic [4:0]  unit_type;
	logic        sps_seen;
	logic        pps_seen;
	logic        idr_seen;
	logic        last_of_run;

	// Predictor state: a private copy of the splitter's registers.
	logic [1:0]  zeros_held    = '0;
	logic [31:0] unit_bytes    = '0;
	logic [4:0]  unit_nal_type = '0;
	logic        seen_sps      = 1'b0;
	logic        seen_pps      = 1'b0;
	logic        seen_idr      = 1'b0;

	nal_result_t step_results [$];     // results of the byte just accepted
	nal_result_t pending_results [$];  // results owed by the block, oldest first

	int  mismatch_count = 0;
	int  idle_cycles    = 0;
	bit  no_idle        = 1'b0;        // both sides run flat out while set

	annexb_to_length_prefixed_nal #(
		.LENGTH_BITS(LENGTH_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.out_byte     (out_byte),
		.unit_length  (unit_length),
		.unit_type    (unit_type),
		.sps_seen     (sps_seen),
		.pps_seen     (pps_seen),
		.idr_seen     (idr_seen),
		.last_of_run  (last_of_run)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Pass one byte into the current unit; the first byte fixes the NAL type.
	function void pass_unit_byte(input logic [7:0] b);
		if (unit_bytes == 0)
			unit_nal_type = b[4:0];
		if (unit_bytes < UNIT_LEN_MAX[31:0])
			unit_bytes++;
		step_results.push_back('{anl_pkg::KIND_PAYLOAD, b, 32'd0, 5'd0,
			seen_sps, seen_pps, seen_idr, 1'b0});
	endfunction

	// Close the current unit; only a non-empty unit gets a descriptor.
	function void close_unit();
		if (unit_bytes != 0) begin
			if (unit_nal_type == anl_pkg::NAL_TYPE_SPS) seen_sps = 1'b1;
			if (unit_nal_type == anl_pkg::NAL_TYPE_PPS) seen_pps = 1'b1;
			if (unit_nal_type == anl_pkg::NAL_TYPE_IDR) seen_idr = 1'b1;
			step_results.push_back('{anl_pkg::KIND_DESCRIPTOR, 8'h00, unit_bytes,
				unit_nal_type, seen_sps, seen_pps, seen_idr, 1'b0});
		end
		unit_bytes    = '0;
		unit_nal_type = '0;
	endfunction

	// Work out the results of one accepted stream byte into step_results.
	function void split_stream_byte(input logic [7:0] b, input logic eob);
		nal_result_t tail;
		step_results.delete();
		if (b == anl_pkg::BYTE_ZERO) begin
			// hold up to three zeros; a fourth pushes the oldest out
			if (zeros_held < anl_pkg::HELD_MAX)
				zeros_held++;
			else
				pass_unit_byte(anl_pkg::BYTE_ZERO);
		end else if (b == anl_pkg::BYTE_START_END && zeros_held == anl_pkg::HELD_MAX) begin
			// start code: drop the zeros and the 01, end the unit
			zeros_held = '0;
			close_unit();
		end else begin
			// release held zeros ahead of the byte
			for (int k = 0; k < zeros_held; k++)
				pass_unit_byte(anl_pkg::BYTE_ZERO);
			zeros_held = '0;
			pass_unit_byte(b);
		end
		if (eob) begin
			// flush leftovers and the pending unit; sticky flags survive
			for (int k = 0; k < zeros_held; k++)
				pass_unit_byte(anl_pkg::BYTE_ZERO);
			zeros_held = '0;
			close_unit();
		end
		if (step_results.size() > 0) begin
			tail      = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
	endfunction

	// Queue what the block owes for the byte just accepted.
	function void owe_results(input logic typed, input logic has_result,
			input nal_result_t result);
		if (typed) begin
			if (has_result)
				pending_results.push_back(result);
		end else begin
			foreach (step_results[k])
				pending_results.push_back(step_results[k]);
		end
	endfunction

	function void report_mismatch(input string what, input nal_result_t exp_r,
			input nal_result_t got_r);
		string exp_s;
		string got_s;
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			exp_s = $sformatf("kind=%0d byte=%02h len=%0d type=%0d spi=%b%b%b last=%b",
				exp_r.kind, exp_r.data, exp_r.length, exp_r.nal_type,
				exp_r.sps, exp_r.pps, exp_r.idr, exp_r.last);
			got_s = $sformatf("kind=%0d byte=%02h len=%0d type=%0d spi=%b%b%b last=%b",
				got_r.kind, got_r.data, got_r.length, got_r.nal_type,
				got_r.sps, got_r.pps, got_r.idr, got_r.last);
			$display("%0t mismatch (%s): exp %s, got %s", $realtime, what, exp_s, got_s);
		end
	endfunction

	// Offer one byte after a random gap, or none while no_idle is set; hold it until the block takes it.
	task automatic send_stream_byte(input logic [7:0] b, input logic eob);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (in_stall);
	endtask

	// Output monitor: compare each taken result with the oldest one owed,
	// and count cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		nal_result_t got;
		nal_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{kind, out_byte, unit_length, unit_type,
					sps_seen, pps_seen, idr_seen, last_of_run};
				if (pending_results.size() == 0) begin
					report_mismatch("nothing owed", NO_RESULT, got);
				end else begin
					want = pending_results.pop_front();
					if (got.kind !== want.kind || got.data !== want.data
							|| got.length !== want.length || got.nal_type !== want.nal_type
							|| got.sps !== want.sps || got.pps !== want.pps
							|| got.idr !== want.idr || got.last !== want.last)
						report_mismatch("field", want, got);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Result sink: random stalls per transaction, stretches with none,
	// and one long hold-off so the command queue fills and stalls the input.
	initial begin : result_sink
		int  hold;
		int  taken;
		bit  pressure_done;
		taken         = 0;
		pressure_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!pressure_done && taken >= PRESSURE_AFTER) begin
				pressure_done = 1'b1;
				out_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Timeout: stop when nothing has moved for too long.
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		stream_item_t random_stream [$];
		stream_item_t item;
		logic [7:0]   hdr;
		int           pick;
		int           body_len;
		int           run_len;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table.
		foreach (DIRECTED[r]) begin
			send_stream_byte(DIRECTED[r].data, DIRECTED[r].eob);
			split_stream_byte(DIRECTED[r].data, DIRECTED[r].eob);
			owe_results(DIRECTED[r].typed, DIRECTED[r].has_result, DIRECTED[r].result);
		end

		// Random part: mostly well-formed units with random bodies,
		// the rest noise, broken start codes and loose zero runs.
		while (random_stream.size() < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if ($urandom_range(0, 5) == 0)
					random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
				repeat (3) random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
				random_stream.push_back('{anl_pkg::BYTE_START_END, 1'b0});
				hdr = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 4))
					0: hdr[4:0] = anl_pkg::NAL_TYPE_SPS;
					1: hdr[4:0] = anl_pkg::NAL_TYPE_PPS;
					2: hdr[4:0] = anl_pkg::NAL_TYPE_IDR;
					default: ;
				endcase
				random_stream.push_back('{hdr, 1'b0});
				body_len = $urandom_range(0, 10);
				for (int j = 0; j < body_len; j++) begin
					if ($urandom_range(0, 4) == 0) begin
						run_len = $urandom_range(1, 4);
						repeat (run_len)
							random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
					end else begin
						random_stream.push_back('{8'($urandom_range(1, 255)), 1'b0});
					end
				end
			end else if (pick == 7) begin
				run_len = $urandom_range(1, 6);
				repeat (run_len) random_stream.push_back('{8'($urandom_range(0, 255)), 1'b0});
			end else if (pick == 8) begin
				case ($urandom_range(0, 2))
					0: begin
						repeat (2) random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
						random_stream.push_back('{anl_pkg::BYTE_START_END, 1'b0});
					end
					1: begin
						repeat (3) random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
						random_stream.push_back('{8'h02, 1'b0});
					end
					default: begin
						repeat (5) random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
						random_stream.push_back('{anl_pkg::BYTE_START_END, 1'b0});
					end
				endcase
			end else begin
				run_len = $urandom_range(1, 7);
				repeat (run_len) random_stream.push_back('{anl_pkg::BYTE_ZERO, 1'b0});
			end
			// now and then end the buffer on the last byte of the piece
			if ($urandom_range(0, 6) == 0) begin
				item     = random_stream.pop_back();
				item.eob = 1'b1;
				random_stream.push_back(item);
			end
		end

		foreach (random_stream[i]) begin
			// pick idle stretches or flat-out bursts at random
			if (i % BURST_SPAN == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_stream_byte(random_stream[i].data, random_stream[i].eob);
			split_stream_byte(random_stream[i].data, random_stream[i].eob);
			owe_results(1'b0, 1'b0, NO_RESULT);
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		// Drain: wait for every owed result, then watch for strays.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/anl_pkg.sv
src/anl_front.sv
src/anl_cmdq.sv
src/anl_back.sv
src/annexb_to_length_prefixed_nal.sv
bench/tb_top.sv
